// ===== sv/mwpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpl_pkg
// Shared types, constants and tables of the multi-wall path loss unit.
// ----------------------------------------------------------------------------
package mwpl_pkg;

	localparam int MAX_WALLS  = 16;
	localparam int COORD_BITS = 10;
	localparam int SLOT_BITS  = $clog2(MAX_WALLS);
	localparam int CNT_BITS   = $clog2(MAX_WALLS + 1);
	localparam int LOSS_BITS  = 16;
	localparam int WALL_BITS  = 4 * COORD_BITS + LOSS_BITS;
	localparam int D2_BITS    = 2 * COORD_BITS + 1;
	localparam int EXP_BITS   = $clog2(D2_BITS);
	localparam int LOG_BITS   = EXP_BITS + 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS + 1;
	localparam int ACC_BITS   = 24;
	// Five times log10(2) in Q16.
	localparam logic [16:0] LOG10_2_X5 = 17'd98640;

	// Configuration register indexes.
	localparam logic [2:0] REG_TX_X       = 3'd0;
	localparam logic [2:0] REG_TX_Y       = 3'd1;
	localparam logic [2:0] REG_TX_POWER   = 3'd2;
	localparam logic [2:0] REG_BASE_LOSS  = 3'd3;
	localparam logic [2:0] REG_SLOPE      = 3'd4;
	localparam logic [2:0] REG_WALL_COUNT = 3'd5;

	localparam logic OP_LOAD_WALL = 1'b0;
	localparam logic OP_CELL      = 1'b1;

	typedef struct packed {
		logic [COORD_BITS-1:0] ax;
		logic [COORD_BITS-1:0] ay;
		logic [COORD_BITS-1:0] bx;
		logic [COORD_BITS-1:0] by;
		logic [LOSS_BITS-1:0]  loss;
	} wall_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_DIST,
		ST_NORM,
		ST_LOG,
		ST_TERM,
		ST_WALL_RD,
		ST_O1,
		ST_O2,
		ST_O3,
		ST_O4,
		ST_O5,
		ST_O6,
		ST_O7,
		ST_O8,
		ST_SUM,
		ST_OUT
	} state_t;

	// log2(1 + i/16) in Q16.
	function automatic logic [16:0] log2_tab(input logic [4:0] i);
		logic [16:0] t;
		unique case (i)
			5'd0:  t = 17'd0;
			5'd1:  t = 17'd5732;
			5'd2:  t = 17'd11136;
			5'd3:  t = 17'd16248;
			5'd4:  t = 17'd21098;
			5'd5:  t = 17'd25711;
			5'd6:  t = 17'd30109;
			5'd7:  t = 17'd34312;
			5'd8:  t = 17'd38336;
			5'd9:  t = 17'd42196;
			5'd10: t = 17'd45904;
			5'd11: t = 17'd49472;
			5'd12: t = 17'd52911;
			5'd13: t = 17'd56229;
			5'd14: t = 17'd59434;
			5'd15: t = 17'd62534;
			5'd16: t = 17'd65536;
			default: t = 17'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== sv/mwpl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpl_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module mwpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== sv/mwpl_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpl_core
// Sequencer and shared multiplier datapath for one cell item.
// ----------------------------------------------------------------------------
module mwpl_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [mwpl_pkg::COORD_BITS-1:0]       cx,
	input  logic [mwpl_pkg::COORD_BITS-1:0]       cy,
	input  logic [mwpl_pkg::COORD_BITS-1:0]       tx_x,
	input  logic [mwpl_pkg::COORD_BITS-1:0]       tx_y,
	input  logic signed [15:0]                    tx_power,
	input  logic signed [16:0]                    base_loss,
	input  logic [3:0]                            slope,
	input  logic [4:0]                            wall_count,
	output logic [mwpl_pkg::SLOT_BITS-1:0]        rd_addr,
	input  mwpl_pkg::wall_t                       rd_wall,
	output logic                                  busy,
	output logic                                  done,
	output logic signed [15:0]                    rx_power,
	output logic [4:0]                            walls_crossed
);
	import mwpl_pkg::*;

	state_t state_q, state_d;

	logic signed [DIFF_BITS-1:0] dx_q, dy_q;
	logic [D2_BITS-1:0]          d2_q;
	logic [EXP_BITS-1:0]         e_q;
	logic [15:0]                 f_q;
	logic [LOG_BITS-1:0]         log_q;
	logic [ACC_BITS+16:0]        term_q;
	logic signed [PROD_BITS:0]   part_q;
	logic signed [PROD_BITS:0]   den_q;
	logic signed [PROD_BITS:0]   oc1_q, oc2_q;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic [CNT_BITS-1:0]         cnt_q;
	logic [CNT_BITS-1:0]         nwall;
	logic [4:0]                  crossed_q;
	logic                        zero_q;
	wall_t                       w_q;

	// Shared multiplier: one signed 26 x 18 product per cycle.
	logic signed [25:0]          ma;
	logic signed [17:0]          mb;
	logic signed [43:0]          mp;
	assign mp = ma * mb;

	assign nwall = (wall_count > 5'(MAX_WALLS)) ? CNT_BITS'(MAX_WALLS) : CNT_BITS'(wall_count);
	assign rd_addr = cnt_q[SLOT_BITS-1:0];
	assign busy = (state_q != ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_d = ST_SQ;
			ST_SQ:      state_d = ST_DIST;
			ST_DIST:    state_d = ST_NORM;
			ST_NORM:    state_d = zero_q ? ST_OUT : ST_LOG;
			ST_LOG:     state_d = ST_TERM;
			ST_TERM:    state_d = ST_WALL_RD;
			ST_WALL_RD: state_d = (cnt_q < nwall) ? ST_O1 : ST_SUM;
			ST_O1:      state_d = ST_O2;
			ST_O2:      state_d = ST_O3;
			ST_O3:      state_d = ST_O4;
			ST_O4:      state_d = ST_O5;
			ST_O5:      state_d = ST_O6;
			ST_O6:      state_d = ST_O7;
			ST_O7:      state_d = ST_O8;
			ST_O8:      state_d = ST_WALL_RD;
			ST_SUM:     state_d = ST_OUT;
			ST_OUT:     state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Multiplier operand selection.
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_SQ: begin
				ma = 26'(dx_q);
				mb = 18'(dx_q);
			end
			ST_DIST: begin
				ma = 26'(dy_q);
				mb = 18'(dy_q);
			end
			ST_LOG: begin
				ma = 26'(signed'({1'b0, log2_tab({1'b0, f_q[15:12]} + 5'd1)
					- log2_tab({1'b0, f_q[15:12]})}));
				mb = 18'(signed'({1'b0, f_q[11:0]}));
			end
			ST_TERM: begin
				ma = 26'(signed'({1'b0, log_q}));
				mb = 18'(signed'({1'b0, slope}));
			end
			ST_SUM: begin
				ma = 26'(signed'({1'b0, term_q[24:0]}));
				mb = 18'(signed'({1'b0, LOG10_2_X5}));
			end
			// Denominator of the two lines.
			ST_O1: begin
				ma = 26'(dx_q);
				mb = 18'(signed'({1'b0, w_q.by}) - signed'({1'b0, w_q.ay}));
			end
			ST_O2: begin
				ma = 26'(dy_q);
				mb = 18'(signed'({1'b0, w_q.bx}) - signed'({1'b0, w_q.ax}));
			end
			// Side of wall endpoint A against the path.
			ST_O3: begin
				ma = 26'(dx_q);
				mb = 18'(signed'({1'b0, w_q.ay}) - signed'({1'b0, tx_y}));
			end
			ST_O4: begin
				ma = 26'(dy_q);
				mb = 18'(signed'({1'b0, w_q.ax}) - signed'({1'b0, tx_x}));
			end
			// Side of wall endpoint B against the path.
			ST_O5: begin
				ma = 26'(dx_q);
				mb = 18'(signed'({1'b0, w_q.by}) - signed'({1'b0, tx_y}));
			end
			ST_O6: begin
				ma = 26'(dy_q);
				mb = 18'(signed'({1'b0, w_q.bx}) - signed'({1'b0, tx_x}));
			end
			// Side of the transmitter against the wall.
			ST_O7: begin
				ma = 26'(signed'({1'b0, w_q.bx}) - signed'({1'b0, w_q.ax}));
				mb = 18'(signed'({1'b0, tx_y}) - signed'({1'b0, w_q.ay}));
			end
			ST_O8: begin
				ma = 26'(signed'({1'b0, w_q.by}) - signed'({1'b0, w_q.ay}));
				mb = 18'(signed'({1'b0, tx_x}) - signed'({1'b0, w_q.ax}));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Crossing decision from the orientation products of the current wall.
	logic signed [PROD_BITS+1:0] oa1, oa2;
	logic                        hit;
	always_comb begin
		// The cell's side of the wall follows from the transmitter's side and the
		// denominator.
		oa1 = (PROD_BITS+2)'(part_q) - (PROD_BITS+2)'(mp);
		oa2 = oa1 - (PROD_BITS+2)'(den_q);
		hit = (den_q != 0)
			&& !(((oc1_q > 0) && (oc2_q > 0)) || ((oc1_q < 0) && (oc2_q < 0)))
			&& !(((oa1 > 0) && (oa2 > 0)) || ((oa1 < 0) && (oa2 < 0)));
	end

	// Normalizer input: highest set bit of d2.
	logic [EXP_BITS-1:0] msb;
	always_comb begin
		msb = '0;
		for (int i = 0; i < D2_BITS; i++) begin
			if (d2_q[i]) msb = EXP_BITS'(i);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				dx_q <= signed'({1'b0, cx}) - signed'({1'b0, tx_x});
				dy_q <= signed'({1'b0, cy}) - signed'({1'b0, tx_y});
			end
			ST_SQ: begin
				d2_q <= D2_BITS'(mp);
			end
			ST_DIST: begin
				d2_q <= d2_q + D2_BITS'(mp);
			end
			ST_NORM: begin
				e_q <= msb;
				f_q <= 16'(({16'b0, d2_q} << 16) >> msb);
				zero_q <= 1'b0;
			end
			ST_LOG: begin
				log_q <= {e_q, 16'b0} + LOG_BITS'(log2_tab({1'b0, f_q[15:12]}))
					+ LOG_BITS'(mp[40:12]);
			end
			ST_TERM: begin
				term_q <= (ACC_BITS+17)'(mp[40:0]);
				acc_q <= ACC_BITS'(tx_power) - ACC_BITS'(base_loss);
			end
			ST_WALL_RD: begin
				w_q <= rd_wall;
			end
			ST_O1: part_q <= (PROD_BITS+1)'(mp);
			ST_O2: den_q <= part_q - (PROD_BITS+1)'(mp);
			ST_O3: part_q <= (PROD_BITS+1)'(mp);
			ST_O4: oc1_q <= part_q - (PROD_BITS+1)'(mp);
			ST_O5: part_q <= (PROD_BITS+1)'(mp);
			ST_O6: oc2_q <= part_q - (PROD_BITS+1)'(mp);
			ST_O7: part_q <= (PROD_BITS+1)'(mp);
			ST_O8: begin
				if (hit) begin
					acc_q <= acc_q - ACC_BITS'(signed'({1'b0, w_q.loss}));
				end
			end
			ST_SUM: begin
				acc_q <= acc_q - ACC_BITS'(signed'({1'b0,
					18'((mp[42:0] + 43'(1 << 23)) >> 24)}));
			end
			default: begin
			end
		endcase
		if (state_q == ST_IDLE && start) begin
			zero_q <= (cx == tx_x) && (cy == tx_y);
			acc_q <= ACC_BITS'(tx_power);
		end
	end

	// Control registers. The wall counter steps as a wall is captured, so the
	// table read of the next wall is under way during the products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			crossed_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
				crossed_q <= '0;
			end else if (state_q == ST_WALL_RD) begin
				if (cnt_q < nwall) cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_O8) begin
				if (hit) crossed_q <= crossed_q + 1'b1;
			end
		end
	end

	// Result: saturate the accumulated power.
	always_comb begin
		done = (state_q == ST_OUT);
		walls_crossed = crossed_q;
		if (acc_q > 24'sd32767) rx_power = 16'sh7FFF;
		else if (acc_q < -24'sd32768) rx_power = -16'sh8000;
		else rx_power = acc_q[15:0];
	end

endmodule

// ===== sv/multi_wall_path_loss_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_wall_path_loss_unit
// Received power at a grid cell under a multi-wall indoor path-loss model.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// s_axis    in         tvalid/tready        tdata, tuser = opcode
// m_axis    out        tvalid/tready        tdata
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A wall item goes into the wall table on acceptance; the input stays ready.
// A cell item runs eight multiplier steps per wall on the shared multiplier,
// plus one table read; the transmitter's own cell skips the log and wall steps.
// Reset clears the registers to their defaults; wall entries are undefined
// until loaded. The input stalls while a cell item is at work or while its
// result waits in the output register.
// ----------------------------------------------------------------------------
module multi_wall_path_loss_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// wall_slot[3:0], point_a_x[13:4], point_a_y[23:14], point_b_x[33:24],
	// point_b_y[43:34], wall_loss[59:44], zero fill
	input  logic [63:0] s_axis_tdata,
	// opcode[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// rx_power[15:0], walls_crossed[20:16], zero fill
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import mwpl_pkg::*;

	logic [COORD_BITS-1:0] tx_x_q, tx_y_q;
	logic signed [15:0]    tx_power_q;
	logic signed [16:0]    base_loss_q;
	logic [3:0]            slope_q;
	logic [4:0]            wall_count_q;
	logic                  out_valid_q;
	logic [23:0]           out_data_q;
	logic                  busy, done, in_fire, load;
	logic [SLOT_BITS-1:0]  rd_addr;
	wall_t                 rd_wall, wr_wall;
	logic signed [15:0]    rx_power;
	logic [4:0]            walls_crossed;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !busy && !out_valid_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign load = in_fire && (s_axis_tuser == OP_LOAD_WALL);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	assign wr_wall = '{ax: s_axis_tdata[13:4], ay: s_axis_tdata[23:14],
		bx: s_axis_tdata[33:24], by: s_axis_tdata[43:34], loss: s_axis_tdata[59:44]};

	// Wall table.
	mwpl_ram #(.WIDTH(WALL_BITS), .DEPTH(MAX_WALLS)) u_wall_ram (
		.clk     (clk),
		.wr_en   (load),
		.wr_addr (s_axis_tdata[SLOT_BITS-1:0]),
		.wr_data (wr_wall),
		.rd_addr (rd_addr),
		.rd_data (rd_wall)
	);

	mwpl_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_fire && (s_axis_tuser == OP_CELL)),
		.cx            (s_axis_tdata[13:4]),
		.cy            (s_axis_tdata[23:14]),
		.tx_x          (tx_x_q),
		.tx_y          (tx_y_q),
		.tx_power      (tx_power_q),
		.base_loss     (base_loss_q),
		.slope         (slope_q),
		.wall_count    (wall_count_q),
		.rd_addr       (rd_addr),
		.rd_wall       (rd_wall),
		.busy          (busy),
		.done          (done),
		.rx_power      (rx_power),
		.walls_crossed (walls_crossed)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_x_q <= '0;
			tx_y_q <= '0;
			tx_power_q <= 16'sd5120;
			base_loss_q <= '0;
			slope_q <= 4'd2;
			wall_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TX_X:       tx_x_q <= cfg_data[COORD_BITS-1:0];
				REG_TX_Y:       tx_y_q <= cfg_data[COORD_BITS-1:0];
				REG_TX_POWER:   tx_power_q <= cfg_data[15:0];
				REG_BASE_LOSS:  base_loss_q <= cfg_data;
				REG_SLOPE:      slope_q <= cfg_data[3:0];
				REG_WALL_COUNT: wall_count_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= {3'b0, walls_crossed, rx_power};
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-wall path loss unit testbench
// Loads walls, sets the transmitter and loss registers through the
// configuration channel, sends cell items with random gaps and output stalls,
// and compares every received power and crossing count with a prediction.
// ----------------------------------------------------------------------------
module testbench;
	import mwpl_pkg::*;

	// Expected result of one cell item.
	typedef struct {
		logic signed [15:0] rx_power;
		logic [4:0]         walls_crossed;
	} cell_result_t;

	// Predicts received power and keeps the pending results in order.
	class power_scoreboard;
		logic [9:0]         tx_x, tx_y;
		logic signed [15:0] tx_power;
		logic signed [16:0] base_loss;
		logic [3:0]         slope;
		logic [4:0]         wall_count;
		wall_t              walls [MAX_WALLS];
		cell_result_t       pending [$];
		int                 errors;

		function new();
			tx_x = 0;
			tx_y = 0;
			tx_power = 5120;
			base_loss = 0;
			slope = 2;
			wall_count = 0;
			errors = 0;
			for (int k = 0; k < MAX_WALLS; k++) walls[k] = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [16:0] val);
			case (idx)
				REG_TX_X:       tx_x = val[9:0];
				REG_TX_Y:       tx_y = val[9:0];
				REG_TX_POWER:   tx_power = val[15:0];
				REG_BASE_LOSS:  base_loss = val;
				REG_SLOPE:      slope = val[3:0];
				REG_WALL_COUNT: wall_count = val[4:0];
				default: ;
			endcase
		endfunction

		function longint sgn(longint v);
			return (v > 0) - (v < 0);
		endfunction

		function longint orient(longint ox, longint oy, longint px, longint py,
				longint qx, longint qy);
			return (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
		endfunction

		// Exact segment test; parallel walls are never crossed.
		function bit path_crosses(longint px, longint py, longint cx, longint cy,
				wall_t w);
			longint ax, ay, bx, by;
			ax = w.ax; ay = w.ay; bx = w.bx; by = w.by;
			if ((cx - px) * (by - ay) - (cy - py) * (bx - ax) == 0) return 0;
			if (sgn(orient(px, py, cx, cy, ax, ay)) *
				sgn(orient(px, py, cx, cy, bx, by)) > 0) return 0;
			if (sgn(orient(ax, ay, bx, by, px, py)) *
				sgn(orient(ax, ay, bx, by, cx, cy)) > 0) return 0;
			return 1;
		endfunction

		function longint log2_q16(longint v);
			int e, f, i, r;
			longint t0, t1;
			e = 0;
			while (e < 62 && (v >> (e + 1)) != 0) e++;
			if (e >= 16) f = (v >> (e - 16)) & 16'hFFFF;
			else f = (v << (16 - e)) & 16'hFFFF;
			i = f >> 12;
			r = f & 4095;
			t0 = log2_tab(i);
			t1 = log2_tab(i + 1);
			return (longint'(e) << 16) + t0 + (((t1 - t0) * r) >>> 12);
		endfunction

		// Note an accepted item and predict its result, if it has one.
		function void note_item(logic op, logic [59:0] d);
			longint ax, ay, px, py, d2, term, rx;
			int crossed, n;
			ax = d[13:4];
			ay = d[23:14];
			if (op == OP_LOAD_WALL) begin
				walls[d[3:0]] = {d[13:4], d[23:14], d[33:24], d[43:34], d[59:44]};
				return;
			end
			px = tx_x;
			py = tx_y;
			d2 = (ax - px) * (ax - px) + (ay - py) * (ay - py);
			crossed = 0;
			if (d2 == 0) begin
				rx = tx_power;
			end else begin
				term = (longint'(slope) * log2_q16(d2) * 5 * 19728 + (64'd1 << 23)) >>> 24;
				rx = longint'(tx_power) - longint'(base_loss) - term;
				n = (wall_count > MAX_WALLS) ? MAX_WALLS : wall_count;
				for (int k = 0; k < n; k++) begin
					if (path_crosses(px, py, ax, ay, walls[k])) begin
						rx -= walls[k].loss;
						if (crossed < 31) crossed++;
					end
				end
			end
			if (rx > 32767) rx = 32767;
			if (rx < -32768) rx = -32768;
			pending.push_back('{rx_power: rx[15:0], walls_crossed: crossed[4:0]});
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(logic [23:0] d);
			cell_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (d[15:0] !== exp_r.rx_power) begin
				$display("%0t: rx_power expected %0d actual %0d", $time,
					exp_r.rx_power, $signed(d[15:0]));
				errors++;
			end
			if (d[20:16] !== exp_r.walls_crossed) begin
				$display("%0t: walls_crossed expected %0d actual %0d", $time,
					exp_r.walls_crossed, d[20:16]);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [16:0] cfg_data;

	power_scoreboard sb;
	int              idle_cycles;
	bit              stall_enable;

	multi_wall_path_loss_unit u_top (.*);

	// Clock generation.
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Short gaps mostly, with an occasional long one.
	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Output stalls and acceptance of results.
	initial begin
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			m_axis_tready = !stall_enable || ($urandom_range(0, 3) != 0);
		end
	end

	// Monitor and watchdog at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [16:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Send one item, waiting a random gap first when asked.
	task automatic send_item(logic op, logic [59:0] d, bit gaps);
		int g;
		g = gaps ? gap_length() : 0;
		@(negedge clk);
		if (g > 0) begin
			s_axis_tvalid = 0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tuser = op;
		s_axis_tdata = {4'd0, d};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(op, d);
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	function automatic logic [59:0] pack_item(int slot, int ax, int ay, int bx, int by,
			int loss);
		return {loss[15:0], by[9:0], bx[9:0], ay[9:0], ax[9:0], slot[3:0]};
	endfunction

	function automatic logic [59:0] random_wall(int slot);
		return pack_item(slot, $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 65535));
	endfunction

	// Wait until every expected result is in, then let the block settle.
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (7 + 6 * MAX_WALLS + 10) @(posedge clk);
	endtask

	task automatic load_all_walls(bit gaps);
		for (int k = 0; k < MAX_WALLS; k++) send_item(OP_LOAD_WALL, random_wall(k), gaps);
	endtask

	task automatic random_phase(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(OP_LOAD_WALL, random_wall($urandom_range(0, 15)), 1);
			else
				send_item(OP_CELL, pack_item($urandom_range(0, 15), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 65535)), 1);
		end
		end_burst();
		drain();
	endtask

	initial begin
		sb = new();
		idle_cycles = 0;
		stall_enable = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: default registers, no walls, transmitter cell and far corner.
		send_item(OP_CELL, pack_item(0, 0, 0, 0, 0, 0), 0);
		send_item(OP_CELL, pack_item(15, 1023, 1023, 1023, 1023, 65535), 0);
		send_item(OP_CELL, pack_item(0, 1, 0, 0, 0, 0), 0);
		end_burst();
		drain();

		// Directed: one crossing wall, touching endpoint, parallel and zero-length.
		write_reg(REG_TX_X, 17'd100);
		write_reg(REG_TX_Y, 17'd100);
		write_reg(REG_WALL_COUNT, 17'd4);
		send_item(OP_LOAD_WALL, pack_item(0, 150, 0, 150, 300, 1000), 0);
		send_item(OP_LOAD_WALL, pack_item(1, 200, 200, 300, 100, 65535), 0);
		send_item(OP_LOAD_WALL, pack_item(2, 0, 110, 500, 110, 500), 0);
		send_item(OP_LOAD_WALL, pack_item(3, 120, 120, 120, 120, 700), 0);
		send_item(OP_CELL, pack_item(0, 200, 100, 0, 0, 0), 0);
		send_item(OP_CELL, pack_item(0, 200, 200, 0, 0, 0), 0);
		send_item(OP_CELL, pack_item(0, 300, 300, 0, 0, 0), 0);
		send_item(OP_CELL, pack_item(0, 100, 100, 0, 0, 0), 0);
		send_item(OP_CELL, pack_item(0, 500, 100, 0, 0, 0), 0);
		end_burst();
		drain();

		// Directed: extreme registers, saturation both ways, slope zero, count above max.
		write_reg(REG_TX_POWER, 17'h08000);
		write_reg(REG_BASE_LOSS, 17'h0FFFF);
		write_reg(REG_SLOPE, 17'd15);
		write_reg(REG_WALL_COUNT, 17'd31);
		load_all_walls(0);
		send_item(OP_CELL, pack_item(0, 1023, 1023, 0, 0, 0), 0);
		send_item(OP_CELL, pack_item(0, 0, 0, 0, 0, 0), 0);
		end_burst();
		drain();
		write_reg(REG_TX_POWER, 17'h07FFF);
		write_reg(REG_BASE_LOSS, 17'h10000);
		write_reg(REG_SLOPE, 17'd0);
		write_reg(REG_WALL_COUNT, 17'd0);
		send_item(OP_CELL, pack_item(0, 1023, 0, 0, 0, 0), 0);
		end_burst();
		drain();

		// Random phases over several register settings.
		stall_enable = 1;
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_TX_X, $urandom_range(0, 1023));
			write_reg(REG_TX_Y, $urandom_range(0, 1023));
			write_reg(REG_TX_POWER, $urandom_range(0, 65535));
			write_reg(REG_BASE_LOSS, $urandom_range(0, 8191));
			write_reg(REG_SLOPE, (p == 0) ? 1 : (p == 1) ? 10 : $urandom_range(0, 15));
			write_reg(REG_WALL_COUNT, (p == 2) ? 0 : (p == 3) ? 16 : $urandom_range(0, 31));
			load_all_walls(1);
			random_phase(65);
		end

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
